>>> hw/rtl/kmp_stream_matcher_core_assert.svh
// Assertion macros shared by the matcher checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef KMP_STREAM_MATCHER_CORE_ASSERT_SVH
`define KMP_STREAM_MATCHER_CORE_ASSERT_SVH

// clocked assertion, disabled while reset is asserted
`define KMP_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent this cycle, consequent on the next cycle
`define KMP_CHK_NEXT(lbl, ante, cons, msg) \
  `KMP_CHK(lbl, (ante) |=> (cons), msg)

`endif

>>> hw/rtl/kmp_pkg.sv
// Package for the KMP stream matcher: sizes, register indexes, FSM type and
// pattern helper functions. No dependencies.
package kmp_pkg;

  localparam int MAX_PATTERN   = 16;
  localparam int POSITION_BITS = 16;
  localparam int IDX_W         = $clog2(MAX_PATTERN);
  localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
  localparam int CFG_DW        = 64;
  localparam int CFG_AW        = 2;
  localparam int START_W       = 16;
  localparam int OUT_W         = 24;

  localparam logic [CFG_AW-1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [CFG_AW-1:0] REG_PAT_LEN  = 2'd2;

  typedef enum logic [2:0] {
    S_BUILD_INIT,
    S_BUILD_CMP,
    S_BUILD_LOAD,
    S_IDLE,
    S_MATCH_LOAD,
    S_MATCH_CMP
  } state_t;

  // pattern length register clamped to 1..MAX_PATTERN
  function automatic logic [LEN_W-1:0] eff_len(input logic [4:0] raw);
    logic [LEN_W-1:0] l;
    if (raw == 5'd0) begin
      l = LEN_W'(1);
    end else if (raw > 5'(MAX_PATTERN)) begin
      l = LEN_W'(MAX_PATTERN);
    end else begin
      l = LEN_W'(raw);
    end
    return l;
  endfunction

  function automatic logic [7:0] pat_byte(input logic [CFG_DW-1:0] lo,
                                          input logic [CFG_DW-1:0] hi,
                                          input logic [IDX_W-1:0]  idx);
    logic [CFG_DW-1:0] w;
    w = idx[3] ? hi : lo;
    w = w >> {idx[2:0], 3'b000};
    return w[7:0];
  endfunction

endpackage

>>> hw/rtl/kmp_stream_matcher_core.sv
// KMP stream matcher top level: pattern registers, failure table memory and the
// table build and per-byte match sequencers. Uses kmp_pkg.
// Per byte: the idle state accepts it, the compare state registers the result when the output
// is free; a byte after a full match starts in the load state, and each failure-table step
// adds a memory read and a load. A new byte is taken only in the idle state. After reset or a
// pattern write the table rebuilds, in_tready low meanwhile. Reset is synchronous, active low.
module kmp_stream_matcher_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // text_byte
  input  logic                      in_tlast,   // last_of_text
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [kmp_pkg::OUT_W-1:0] out_tdata,  // match_found, match_start[16], matched_count[5]
  input  logic                      cfg_we,
  input  logic [kmp_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [kmp_pkg::CFG_DW-1:0] cfg_wdata
);
  import kmp_pkg::*;

  state_t state_r, state_nxt;

  logic [CFG_DW-1:0]        pat_lo_r, pat_lo_nxt;
  logic [CFG_DW-1:0]        pat_hi_r, pat_hi_nxt;
  logic [4:0]               pat_len_r, pat_len_nxt;
  logic [LEN_W-1:0]         len;

  logic [LEN_W-1:0]         fail_mem [MAX_PATTERN];
  logic                     mem_we, mem_re;
  logic [IDX_W-1:0]         mem_waddr, mem_raddr;
  logic [LEN_W-1:0]         mem_wdata, mem_rdata_r;

  logic [LEN_W-1:0]         bk_r, bk_nxt;
  logic [LEN_W-1:0]         bq_r, bq_nxt;
  logic [LEN_W-1:0]         mlen_r, mlen_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     found_r, found_nxt;
  logic [POSITION_BITS-1:0] fstart_r, fstart_nxt;
  logic [7:0]               byte_r, byte_nxt;
  logic                     last_r, last_nxt;
  logic [LEN_W-1:0]         q_r, q_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]         out_data_r, out_data_nxt;

  logic [7:0]               pb_k, pb_bq, pb_m;
  logic                     out_free;
  logic                     eq_b, eq_m;
  logic [LEN_W-1:0]         q1_b, q1_m;
  logic                     found_v;
  logic [POSITION_BITS-1:0] start_v;

  assign len      = eff_len(pat_len_r);
  assign pb_k     = pat_byte(pat_lo_r, pat_hi_r, bk_r[IDX_W-1:0]);
  assign pb_bq    = pat_byte(pat_lo_r, pat_hi_r, bq_r[IDX_W-1:0]);
  assign pb_m     = pat_byte(pat_lo_r, pat_hi_r, q_r[IDX_W-1:0]);
  assign eq_b     = (pb_k == pb_bq);
  assign eq_m     = (byte_r == pb_m);
  assign q1_b     = bq_r + LEN_W'(eq_b);
  assign q1_m     = q_r + LEN_W'(eq_m);
  assign out_free = ~out_valid_r | out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    pat_lo_nxt    = pat_lo_r;
    pat_hi_nxt    = pat_hi_r;
    pat_len_nxt   = pat_len_r;
    bk_nxt        = bk_r;
    bq_nxt        = bq_r;
    mlen_nxt      = mlen_r;
    pos_nxt       = pos_r;
    found_nxt     = found_r;
    fstart_nxt    = fstart_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    q_nxt         = q_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    in_tready     = 1'b0;
    found_v       = found_r;
    start_v       = fstart_r;

    unique case (state_r)
      S_BUILD_INIT: begin
        mem_we    = 1'b1;
        bk_nxt    = LEN_W'(1);
        bq_nxt    = '0;
        if (mlen_r > len) begin
          mlen_nxt = len;
        end
        state_nxt = S_BUILD_CMP;
      end
      S_BUILD_CMP: begin
        if (bk_r >= len) begin
          state_nxt = S_IDLE;
        end else if (bq_r != '0 && !eq_b) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(bq_r - LEN_W'(1));
          state_nxt = S_BUILD_LOAD;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = bk_r[IDX_W-1:0];
          mem_wdata = q1_b;
          bq_nxt    = q1_b;
          bk_nxt    = bk_r + LEN_W'(1);
        end
      end
      S_BUILD_LOAD: begin
        bq_nxt    = mem_rdata_r;
        state_nxt = S_BUILD_CMP;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          byte_nxt = in_tdata;
          last_nxt = in_tlast;
          if (pos_r != '1) begin
            pos_nxt = pos_r + POSITION_BITS'(1);
          end
          // a full match last time: start from the failure entry of the whole pattern
          if (mlen_r >= len) begin
            mem_re    = 1'b1;
            mem_raddr = IDX_W'(len - LEN_W'(1));
            state_nxt = S_MATCH_LOAD;
          end else begin
            q_nxt     = mlen_r;
            state_nxt = S_MATCH_CMP;
          end
        end
      end
      S_MATCH_LOAD: begin
        q_nxt     = mem_rdata_r;
        state_nxt = S_MATCH_CMP;
      end
      S_MATCH_CMP: begin
        if (q_r != '0 && !eq_m) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(q_r - LEN_W'(1));
          state_nxt = S_MATCH_LOAD;
        end else if (out_free) begin
          if (q1_m == len && !found_r) begin
            found_v = 1'b1;
            start_v = pos_r - POSITION_BITS'(len) + POSITION_BITS'(1);
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(OUT_W - 1 - START_W - LEN_W)'(0), q1_m,
                           START_W'(start_v), found_v};
          if (last_r) begin
            mlen_nxt   = '0;
            pos_nxt    = '0;
            found_nxt  = 1'b0;
            fstart_nxt = '0;
          end else begin
            mlen_nxt   = q1_m;
            found_nxt  = found_v;
            fstart_nxt = start_v;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_BUILD_INIT;
    endcase

    if (cfg_we) begin
      priority if (cfg_addr == REG_PAT_LOW) begin
        pat_lo_nxt = cfg_wdata;
        state_nxt  = S_BUILD_INIT;
      end else if (cfg_addr == REG_PAT_HIGH) begin
        pat_hi_nxt = cfg_wdata;
        state_nxt  = S_BUILD_INIT;
      end else if (cfg_addr == REG_PAT_LEN) begin
        pat_len_nxt = cfg_wdata[4:0];
        state_nxt   = S_BUILD_INIT;
      end else begin
        pat_len_nxt = pat_len_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BUILD_INIT;
      pat_lo_r    <= '0;
      pat_hi_r    <= '0;
      pat_len_r   <= 5'd1;
      mlen_r      <= '0;
      pos_r       <= '0;
      found_r     <= 1'b0;
      fstart_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pat_lo_r    <= pat_lo_nxt;
      pat_hi_r    <= pat_hi_nxt;
      pat_len_r   <= pat_len_nxt;
      mlen_r      <= mlen_nxt;
      pos_r       <= pos_nxt;
      found_r     <= found_nxt;
      fstart_r    <= fstart_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bk_r       <= bk_nxt;
    bq_r       <= bq_nxt;
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    q_r        <= q_nxt;
    out_data_r <= out_data_nxt;
  end

  // failure table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      fail_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= fail_mem[mem_raddr];
    end
  end

endmodule

>>> hw/rtl/kmp_chk.sv
// Port-level checker for the KMP stream matcher, bound to the top level.
// Uses kmp_pkg and the assertion macros header.
`include "kmp_stream_matcher_core_assert.svh"

module kmp_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [kmp_pkg::OUT_W-1:0]  out_tdata,
  input logic                       cfg_we,
  input logic [kmp_pkg::CFG_AW-1:0] cfg_addr
);
  import kmp_pkg::*;

  logic cfg_hit;
  logic no_match_zero;

  assign cfg_hit       = cfg_we && (cfg_addr == REG_PAT_LOW || cfg_addr == REG_PAT_HIGH ||
                                    cfg_addr == REG_PAT_LEN);
  assign no_match_zero = out_tdata[0] || (out_tdata[START_W:1] == '0);

  // a stalled result holds
  `KMP_CHK_NEXT(a_out_hold, out_tvalid && !out_tready,
                out_tvalid && $stable(out_tdata), "result changed while stalled")
  // input is never accepted back to back
  `KMP_CHK_NEXT(a_in_gap, in_tvalid && in_tready, !in_tready,
                "item accepted on consecutive cycles")
  // a pattern write starts a table rebuild
  `KMP_CHK_NEXT(a_cfg_build, cfg_hit, !in_tready, "input ready during table rebuild")
  // no match reported means no start position
  `KMP_CHK(a_start_zero, out_tvalid |-> no_match_zero, "start set without a match")

endmodule

bind kmp_stream_matcher_core kmp_chk u_kmp_chk (.*);

>>> tb/tb_top.sv
// Testbench for kmp_stream_matcher_core: streams texts through the matcher and checks
// every result item against a KMP predictor kept inside the bench.
// Depends on kmp_pkg and the matcher RTL.
module tb_top;
  import kmp_pkg::*;

  localparam logic [CFG_AW-1:0] REG_UNMAPPED = 2'd3;
  localparam logic [15:0]       POS_MAX      = 16'hFFFF;

  typedef struct packed {
    logic       last_of_text;
    logic [7:0] text_byte;
  } text_item_t;

  typedef struct packed {
    logic        match_found;
    logic [15:0] match_start;
    logic [4:0]  matched_count;
  } match_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;   // text_byte
  logic                in_tlast;   // last_of_text
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_W-1:0]    out_tdata;  // match_found, match_start[16], matched_count[5]
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [CFG_DW-1:0]   cfg_wdata;

  kmp_stream_matcher_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  text_item_t    text_q[$];
  match_result_t match_q[$];
  int            send_idle_pct;
  int            recv_stall_pct;
  int            err_cnt;

  // pattern as the stimulus generator sees it
  logic [7:0] gen_pat [16];
  int         gen_len;
  logic [7:0] gen_alpha [3];

  // predictor state
  logic [63:0] pat_lo_reg;
  logic [63:0] pat_hi_reg;
  logic [4:0]  pat_len_reg;
  logic [4:0]  prefix_tbl [16];
  logic [4:0]  matched_len;
  logic [15:0] text_pos;
  logic        seen_match;
  logic [15:0] first_start;

  function automatic logic [4:0] active_len();
    logic [4:0] l;
    if (pat_len_reg == 5'd0) begin
      l = 5'd1;
    end else if (pat_len_reg > 5'(MAX_PATTERN)) begin
      l = 5'(MAX_PATTERN);
    end else begin
      l = pat_len_reg;
    end
    return l;
  endfunction

  function automatic logic [7:0] pat_at(logic [3:0] k);
    logic [63:0] w;
    w = k[3] ? pat_hi_reg : pat_lo_reg;
    return w[k[2:0]*8 +: 8];
  endfunction

  function automatic void rebuild_prefix();
    logic [4:0] len;
    logic [4:0] q;
    len = active_len();
    q = '0;
    for (int k = 0; k < MAX_PATTERN; k++) prefix_tbl[k] = '0;
    for (int k = 1; k < len; k++) begin
      while (q > 0 && pat_at(4'(k)) != pat_at(q[3:0])) q = prefix_tbl[q-1];
      if (pat_at(4'(k)) == pat_at(q[3:0])) q++;
      prefix_tbl[k] = q;
    end
    // a shorter pattern written mid-text clamps the running count
    if (matched_len > len) matched_len = len;
  endfunction

  function automatic void clear_search();
    matched_len = '0;
    text_pos    = '0;
    seen_match  = 1'b0;
    first_start = '0;
  endfunction

  function automatic void apply_write(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    case (idx)
      REG_PAT_LOW:  pat_lo_reg  = val;
      REG_PAT_HIGH: pat_hi_reg  = val;
      REG_PAT_LEN:  pat_len_reg = val[4:0];
      default:      return;
    endcase
    rebuild_prefix();
  endfunction

  function automatic match_result_t kmp_advance(text_item_t it);
    match_result_t r;
    logic [4:0]    len;
    logic [4:0]    q;
    len = active_len();
    if (text_pos != POS_MAX) text_pos++;
    q = matched_len;
    // after a full match, fall back first so overlapping matches are tracked
    if (q >= len) q = prefix_tbl[len-1];
    while (q > 0 && it.text_byte != pat_at(q[3:0])) q = prefix_tbl[q-1];
    if (it.text_byte == pat_at(q[3:0])) q++;
    matched_len = q;
    if (q == len && !seen_match) begin
      seen_match  = 1'b1;
      first_start = text_pos - 16'(len) + 16'd1;
    end
    r.match_found   = seen_match;
    r.match_start   = first_start;
    r.matched_count = q;
    if (it.last_of_text) clear_search();
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** kmp_stream_matcher_core: FAILED **");
    $finish;
  end

  // text driver
  always @(posedge clk) begin : drive_text
    text_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = text_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.text_byte;
        in_tlast  <= nxt.last_of_text;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predicts on accepted text items and register writes, checks results
  always @(posedge clk) begin : watch
    text_item_t    acc;
    match_result_t want;
    match_result_t got;
    if (!rst_n) begin
      pat_lo_reg  = '0;
      pat_hi_reg  = '0;
      pat_len_reg = 5'd1;
      clear_search();
      rebuild_prefix();
    end else begin
      if (cfg_we) apply_write(cfg_addr, cfg_wdata);
      if (in_tvalid && in_tready) begin
        acc.text_byte    = in_tdata;
        acc.last_of_text = in_tlast;
        match_q.push_back(kmp_advance(acc));
      end
      if (out_tvalid && out_tready) begin
        got.match_found   = out_tdata[0];
        got.match_start   = out_tdata[16:1];
        got.matched_count = out_tdata[21:17];
        if (match_q.size() == 0) begin
          $error("result item with nothing expected: %h", out_tdata);
          err_cnt++;
        end else begin
          want = match_q.pop_front();
          if (got.match_found !== want.match_found) begin
            $error("match_found: expected %0d, got %0d", want.match_found, got.match_found);
            err_cnt++;
          end
          if (got.match_start !== want.match_start) begin
            $error("match_start: expected %0d, got %0d", want.match_start, got.match_start);
            err_cnt++;
          end
          if (got.matched_count !== want.matched_count) begin
            $error("matched_count: expected %0d, got %0d",
                   want.matched_count, got.matched_count);
            err_cnt++;
          end
        end
      end
    end
  end

  task automatic push_text(logic [7:0] b, logic last);
    text_item_t it;
    it.text_byte    = b;
    it.last_of_text = last;
    text_q.push_back(it);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // sampled mid-cycle so the driver and monitor updates of the last edge are settled
  task automatic wait_drained();
    do @(negedge clk); while (text_q.size() != 0 || in_tvalid || match_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
      default: begin send_idle_pct = 17; recv_stall_pct = 17; end
    endcase
  endtask

  // raw_len < 0 picks a length at random; edge_bytes forces the 00/FF alphabet
  task automatic set_random_pattern(int raw_len, bit edge_bytes);
    logic [63:0] lo;
    logic [63:0] hi;
    int          n_alpha;
    int          raw;
    raw = raw_len;
    if (raw < 0) begin
      case ($urandom_range(9))
        0, 1:    raw = 1;
        2, 3:    raw = 16;
        4:       raw = $urandom_range(31, 17);
        default: raw = $urandom_range(15, 2);
      endcase
    end
    gen_len = (raw == 0) ? 1 : (raw > MAX_PATTERN) ? MAX_PATTERN : raw;
    n_alpha = $urandom_range(3, 1);
    for (int i = 0; i < 3; i++) begin
      gen_alpha[i] = edge_bytes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      gen_pat[i] = (i < gen_len) ? gen_alpha[$urandom_range(n_alpha - 1)] : 8'($urandom);
    end
    for (int i = 0; i < 8; i++) begin
      lo[i*8 +: 8] = gen_pat[i];
      hi[i*8 +: 8] = gen_pat[i+8];
    end
    write_reg(REG_PAT_LOW, lo);
    write_reg(REG_PAT_HIGH, hi);
    write_reg(REG_PAT_LEN, 64'(raw));
  endtask

  // texts mostly from the pattern alphabet with whole pattern copies mixed in;
  // a text cut off by the item budget carries over into the next setting
  task automatic queue_texts(int n_items);
    int         left;
    int         tlen;
    int         i;
    int         pick;
    logic [7:0] b;
    left = n_items;
    while (left > 0) begin
      tlen = ($urandom_range(9) == 0) ? 1 : $urandom_range(40, 2);
      i = 0;
      while (i < tlen && left > 0) begin
        pick = $urandom_range(99);
        if (pick < 20) begin
          for (int k = 0; k < gen_len && i < tlen && left > 0; k++) begin
            push_text(gen_pat[k], i == tlen - 1);
            i++;
            left--;
          end
        end else begin
          b = (pick < 85) ? gen_alpha[$urandom_range(2)] : 8'($urandom);
          push_text(b, i == tlen - 1);
          i++;
          left--;
        end
      end
    end
  endtask

  initial begin : stimulus
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    err_cnt    = 0;
    set_idling(0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset pattern: one zero byte
    push_text(8'h00, 1'b0);
    push_text(8'hFF, 1'b0);
    push_text(8'h00, 1'b1);
    wait_drained();

    // length zero acts as one
    write_reg(REG_PAT_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PAT_LEN, 64'd0);
    push_text(8'hFF, 1'b1);
    wait_drained();

    // "ABA" against "ABABA": overlapping second match, start stays at 1
    write_reg(REG_PAT_LOW, 64'h0000_0000_0041_4241);
    write_reg(REG_PAT_LEN, 64'd3);
    push_text(8'h41, 1'b0);
    push_text(8'h42, 1'b0);
    push_text(8'h41, 1'b0);
    push_text(8'h42, 1'b0);
    push_text(8'h41, 1'b1);
    wait_drained();

    // oversized length acts as 16; long fallback on every 'A' past the 15th
    write_reg(REG_PAT_LOW, 64'h4141_4141_4141_4141);
    write_reg(REG_PAT_HIGH, 64'h4241_4141_4141_4141);
    write_reg(REG_PAT_LEN, 64'd31);
    repeat (17) push_text(8'h41, 1'b0);
    wait_drained();
    // shrink mid-text: count clamps to the new length
    write_reg(REG_PAT_LEN, 64'd2);
    push_text(8'h41, 1'b0);
    push_text(8'h42, 1'b1);
    wait_drained();

    write_reg(REG_UNMAPPED, {$urandom, $urandom});

    for (int p = 0; p < 12; p++) begin
      set_idling(p % 4);
      case (p)
        0:       set_random_pattern(16, 1'b0);
        1:       set_random_pattern(1, 1'b0);
        2:       set_random_pattern(0, 1'b1);
        3:       set_random_pattern(31, 1'b0);
        4:       set_random_pattern(-1, 1'b1);
        default: set_random_pattern(-1, 1'b0);
      endcase
      queue_texts(113);
      wait_drained();
    end

    repeat (16) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** kmp_stream_matcher_core: PASSED **");
    end else begin
      $display("** kmp_stream_matcher_core: FAILED **");
    end
    $finish;
  end

endmodule
